### rtl/core/cdd_pkg.sv
// package for the class decision debouncer
// holds class codes, register indexes and the id-to-class mapping function
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cdd_pkg;

    localparam int unsigned TickWidth  = 16;
    localparam int unsigned IdWidth    = 4;
    localparam int unsigned ClassWidth = 3;

    localparam logic [TickWidth-1:0] TICK_MAX = 16'hFFFF;

    // class codes
    localparam logic [ClassWidth-1:0] CODE_STANDING = 3'd0;
    localparam logic [ClassWidth-1:0] CODE_WALKING  = 3'd1;
    localparam logic [ClassWidth-1:0] CODE_SITTING  = 3'd2;
    localparam logic [ClassWidth-1:0] CODE_TURNING  = 3'd3;
    localparam logic [ClassWidth-1:0] CODE_UNKNOWN  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_GUARD_TICKS = 3'd0;
    localparam logic [2:0] REG_SITTING_ID  = 3'd1;
    localparam logic [2:0] REG_STANDING_ID = 3'd2;
    localparam logic [2:0] REG_WALKING_ID  = 3'd3;
    localparam logic [2:0] REG_TURNING_ID  = 3'd4;

    // reset values of the configuration registers
    localparam logic [TickWidth-1:0] GUARD_TICKS_RST = 16'd1000;
    localparam logic [IdWidth-1:0]   SITTING_ID_RST  = 4'd0;
    localparam logic [IdWidth-1:0]   STANDING_ID_RST = 4'd1;
    localparam logic [IdWidth-1:0]   WALKING_ID_RST  = 4'd2;
    localparam logic [IdWidth-1:0]   TURNING_ID_RST  = 4'd3;

    // input kinds
    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_DECISION = 1'b1;

    typedef struct packed {
        logic                  stuck_in_debounce;
        logic                  held_back;
        logic                  committed;
        logic                  raw_moved;
        logic [IdWidth-1:0]    stable_id_out;
        logic [ClassWidth-1:0] stable_class;
        logic [ClassWidth-1:0] raw_class;
    } result_t;

    // first match wins in the order sitting, standing, walking, turning
    function automatic logic [ClassWidth-1:0] class_of(
        input logic [IdWidth-1:0] id,
        input logic [IdWidth-1:0] sitting,
        input logic [IdWidth-1:0] standing,
        input logic [IdWidth-1:0] walking,
        input logic [IdWidth-1:0] turning
    );
        logic [ClassWidth-1:0] code;
        if (id == sitting) begin
            code = CODE_SITTING;
        end else if (id == standing) begin
            code = CODE_STANDING;
        end else if (id == walking) begin
            code = CODE_WALKING;
        end else if (id == turning) begin
            code = CODE_TURNING;
        end else begin
            code = CODE_UNKNOWN;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/core/class_decision_debouncer.sv
// class decision debouncer top level: guard timer, stable state, output register
// depends on cdd_pkg
`timescale 1ns / 1ps
`default_nettype none

// Debounces a stream of classifier decision ids. Each input item is either a
// time tick (s_tuser = 0) or a decision (s_tuser = 1, id in s_tdata[3:0]).
// The first decision after reset becomes the stable id at once. A later
// decision that differs from the stable id becomes a candidate and starts a
// guard timer counted in ticks; when the same candidate arrives again after
// at least guard_ticks ticks it is committed. A decision equal to the stable
// id drops any candidate. Every decision returns one result item with the raw
// and stable ids mapped to class codes through four configurable ids, plus
// change, suppression and debounce flags; ticks return nothing. One item is
// taken per cycle: the state update is a single compare-and-count step done
// as the item is taken, and the result sits in one output register, so the
// input stalls only while that register holds an item the sink has not taken.
// Configuration registers (APB, 32-bit data): 0x00 guard_ticks, 0x04
// sitting_id, 0x08 standing_id, 0x0C walking_id, 0x10 turning_id. A new
// guard_ticks applies at once against ticks already counted.
module class_decision_debouncer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] decision_id, [7:4] zero
    input  wire logic        s_tuser,   // [0] kind
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] raw_class, [5:3] stable_class, [9:6] stable_id_out, [10] raw_moved,
    // [11] committed, [12] held_back, [13] stuck_in_debounce, [15:14] zero
    output logic [15:0]      m_tdata,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned TW = cdd_pkg::TickWidth;
    localparam int unsigned IW = cdd_pkg::IdWidth;

    // configuration registers
    logic [TW-1:0] guard_ticks_reg;
    logic [IW-1:0] sitting_id_reg;
    logic [IW-1:0] standing_id_reg;
    logic [IW-1:0] walking_id_reg;
    logic [IW-1:0] turning_id_reg;

    // debounce state
    logic          have_stable_reg,   have_stable_next;
    logic [IW-1:0] stable_id_reg,     stable_id_next;
    logic [IW-1:0] last_raw_id_reg,   last_raw_id_next;
    logic          pending_flag_reg,  pending_flag_next;
    logic [IW-1:0] pending_id_reg,    pending_id_next;
    logic          timer_running_reg, timer_running_next;
    logic [TW-1:0] elapsed_reg,       elapsed_next;

    // output register
    logic              out_valid_reg;
    cdd_pkg::result_t  out_data_reg;
    cdd_pkg::result_t  result;

    logic          s_accept;
    logic          is_decision;
    logic [IW-1:0] d_id;
    logic          raw_moved;
    logic          committed;
    logic          suppressed;
    logic          cfg_write;
    logic [2:0]    cfg_index;

    // input stalls only when a result is held and the sink does not take it
    assign s_tready    = !out_valid_reg || m_tready;
    assign s_accept    = s_tvalid && s_tready;
    assign is_decision = (s_tuser == cdd_pkg::KIND_DECISION);
    assign d_id        = s_tdata[IW-1:0];

    // ---------------------------------------------------------------------
    // next-state logic for one item
    // ---------------------------------------------------------------------
    always_comb begin
        have_stable_next   = have_stable_reg;
        stable_id_next     = stable_id_reg;
        last_raw_id_next   = last_raw_id_reg;
        pending_flag_next  = pending_flag_reg;
        pending_id_next    = pending_id_reg;
        timer_running_next = timer_running_reg;
        elapsed_next       = elapsed_reg;
        raw_moved          = 1'b0;
        committed          = 1'b0;
        suppressed         = 1'b0;

        if (!is_decision) begin
            // tick: count while the guard runs, saturating
            if (timer_running_reg && (elapsed_reg != cdd_pkg::TICK_MAX)) begin
                elapsed_next = elapsed_reg + TW'(1);
            end
        end else if (!have_stable_reg) begin
            // first decision commits at once
            have_stable_next   = 1'b1;
            stable_id_next     = d_id;
            pending_flag_next  = 1'b0;
            pending_id_next    = '0;
            timer_running_next = 1'b0;
            elapsed_next       = '0;
            raw_moved          = 1'b1;
            committed          = 1'b1;
        end else begin
            raw_moved = (d_id != last_raw_id_reg);
            if (d_id == stable_id_reg) begin
                // back to stable: drop candidate
                pending_flag_next  = 1'b0;
                pending_id_next    = '0;
                timer_running_next = 1'b0;
                elapsed_next       = '0;
            end else if (!pending_flag_reg || (d_id != pending_id_reg)) begin
                // new candidate restarts the guard
                pending_flag_next  = 1'b1;
                pending_id_next    = d_id;
                suppressed         = 1'b1;
                timer_running_next = 1'b1;
                elapsed_next       = '0;
            end else if (timer_running_reg && (elapsed_reg >= guard_ticks_reg)) begin
                // candidate held through the guard: commit
                timer_running_next = 1'b0;
                elapsed_next       = '0;
                stable_id_next     = d_id;
                pending_flag_next  = 1'b0;
                pending_id_next    = '0;
                committed          = 1'b1;
            end else begin
                suppressed = 1'b1;
            end
        end

        if (is_decision) begin
            last_raw_id_next = d_id;
        end
    end

    // result for a decision item
    always_comb begin
        result.raw_class = cdd_pkg::class_of(d_id, sitting_id_reg, standing_id_reg,
                                             walking_id_reg, turning_id_reg);
        result.stable_class = cdd_pkg::class_of(stable_id_next, sitting_id_reg,
                                                standing_id_reg, walking_id_reg,
                                                turning_id_reg);
        result.stable_id_out     = stable_id_next;
        result.raw_moved         = raw_moved;
        result.committed         = committed;
        result.held_back         = suppressed;
        result.stuck_in_debounce = pending_flag_next || (stable_id_next != d_id);
    end

    // ---------------------------------------------------------------------
    // state registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_stable_reg   <= 1'b0;
            stable_id_reg     <= '0;
            last_raw_id_reg   <= '0;
            pending_flag_reg  <= 1'b0;
            pending_id_reg    <= '0;
            timer_running_reg <= 1'b0;
            elapsed_reg       <= '0;
        end else if (s_accept) begin
            have_stable_reg   <= have_stable_next;
            stable_id_reg     <= stable_id_next;
            last_raw_id_reg   <= last_raw_id_next;
            pending_flag_reg  <= pending_flag_next;
            pending_id_reg    <= pending_id_next;
            timer_running_reg <= timer_running_next;
            elapsed_reg       <= elapsed_next;
        end
    end

    // output register: decisions load it, the sink drains it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept) begin
            out_valid_reg <= is_decision;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && is_decision) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    // ---------------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_ticks_reg <= cdd_pkg::GUARD_TICKS_RST;
            sitting_id_reg  <= cdd_pkg::SITTING_ID_RST;
            standing_id_reg <= cdd_pkg::STANDING_ID_RST;
            walking_id_reg  <= cdd_pkg::WALKING_ID_RST;
            turning_id_reg  <= cdd_pkg::TURNING_ID_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                cdd_pkg::REG_GUARD_TICKS: guard_ticks_reg <= pwdata[TW-1:0];
                cdd_pkg::REG_SITTING_ID:  sitting_id_reg  <= pwdata[IW-1:0];
                cdd_pkg::REG_STANDING_ID: standing_id_reg <= pwdata[IW-1:0];
                cdd_pkg::REG_WALKING_ID:  walking_id_reg  <= pwdata[IW-1:0];
                cdd_pkg::REG_TURNING_ID:  turning_id_reg  <= pwdata[IW-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (cfg_index)
            cdd_pkg::REG_GUARD_TICKS: prdata = {16'd0, guard_ticks_reg};
            cdd_pkg::REG_SITTING_ID:  prdata = {28'd0, sitting_id_reg};
            cdd_pkg::REG_STANDING_ID: prdata = {28'd0, standing_id_reg};
            cdd_pkg::REG_WALKING_ID:  prdata = {28'd0, walking_id_reg};
            cdd_pkg::REG_TURNING_ID:  prdata = {28'd0, turning_id_reg};
            default:                  prdata = 32'd0;
        endcase
    end

`ifndef ASSERT_OFF
    // a candidate always has the guard timer running, and only then
    a_pending_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_flag_reg == timer_running_reg)
        else $error("pending candidate and guard timer disagree");

    // a pending candidate never equals the stable id
    a_pending_differs: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_flag_reg |-> (pending_id_reg != stable_id_reg))
        else $error("pending candidate equals stable id");

    // the timer only counts while running
    a_elapsed_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !timer_running_reg |-> (elapsed_reg == '0))
        else $error("guard timer counted while stopped");

    // a result never reports both a commit and a suppression
    a_commit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg.committed && out_data_reg.held_back))
        else $error("commit and suppression in one result");
`endif

endmodule

`default_nettype wire
